// ----- sv/asot_pkg.sv -----
package asot_pkg;

    // Tree grid geometry
    localparam int GRID_BITS  = 6;
    localparam int GRID_SIZE  = 1 << GRID_BITS;
    localparam int NODE_BITS  = 2 * GRID_BITS;
    localparam int NODE_DEPTH = 1 << NODE_BITS;
    localparam logic [GRID_BITS-1:0] MAX_STEPS = GRID_BITS'(GRID_SIZE - 3);

    // Configuration register indexes
    localparam logic [2:0] REG_GEARING_A = 3'd0;
    localparam logic [2:0] REG_GEARING_B = 3'd1;
    localparam logic [2:0] REG_STRIKE    = 3'd2;
    localparam logic [2:0] REG_PUT_MODE  = 3'd3;
    localparam logic [2:0] REG_PROB_UU   = 3'd4;
    localparam logic [2:0] REG_PROB_UD   = 3'd5;
    localparam logic [2:0] REG_PROB_DU   = 3'd6;
    localparam logic [2:0] REG_PROB_DD   = 3'd7;

    typedef struct packed {
        logic [31:0] top_price_one;
        logic [31:0] top_price_two;
        logic [31:0] down_one;
        logic [31:0] down_two;
        logic [5:0]  step_count;
    } t_job;

    typedef struct packed {
        logic [31:0] value_center;
        logic [31:0] value_up_up;
        logic [31:0] value_up_down;
        logic [31:0] value_down_up;
    } t_result;

    // Accumulator preset
    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_MD,
        PRE_WT,
        PRE_STRIKE
    } t_pre;

    // Multiplier operand A
    typedef enum logic [2:0] {
        A_P1,
        A_P2,
        A_RES,
        A_ROWQ,
        A_COLQ,
        A_NODEQ
    } t_asel;

    // Multiplier operand B
    typedef enum logic [2:0] {
        B_D1,
        B_D2,
        B_GA,
        B_NGB,
        B_W0,
        B_W1,
        B_W2,
        B_W3
    } t_bsel;

    // Result finish
    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_MD,
        FIN_WT,
        FIN_INTR
    } t_fin;

    // Controller to datapath commands
    typedef struct packed {
        logic                 ld_job;
        logic [GRID_BITS-1:0] row_addr;
        logic [GRID_BITS-1:0] col_addr;
        logic [NODE_BITS-1:0] node_raddr;
        logic [NODE_BITS-1:0] node_waddr;
        logic                 row_we;
        logic                 col_we;
        logic                 node_we;
        logic                 p1_ld_q;
        logic                 p2_ld_q;
        logic                 p1_ld_res;
        logic                 p2_ld_res;
        t_pre                 preset;
        logic                 mul_en;
        t_asel                a_sel;
        t_bsel                b_sel;
        t_fin                 fin;
        logic                 clr_c;
        logic                 out_ld;
        logic [1:0]           out_sel;
        logic                 emit;
    } t_ctl;

    function automatic logic [NODE_BITS-1:0] node_addr(
        input logic [GRID_BITS-1:0] row,
        input logic [GRID_BITS-1:0] col
    );
        return {row, col};
    endfunction

endpackage

// ----- sv/asot_dpath.sv -----
module asot_dpath import asot_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    input  t_job        i_job,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_result     o_result,
    output logic        o_valid
);

    // Configuration
    logic signed [19:0] r_ga, r_gb;
    logic [31:0]        r_strike;
    logic               r_put;
    logic signed [31:0] r_w0, r_w1, r_w2, r_w3;

    // Job operands and working registers
    logic [31:0] r_d1, r_d2, r_p1, r_p2, r_res, r_c;
    logic [31:0] r_row_q, r_col_q, r_node_q;
    logic signed [65:0] r_prod;
    logic               r_pv;
    logic signed [66:0] r_acc;
    t_result            r_out;
    logic               r_valid;

    // Stores
    logic [31:0] r_node_mem [NODE_DEPTH];
    logic [31:0] r_row_mem  [GRID_SIZE];
    logic [31:0] r_col_mem  [GRID_SIZE];

    logic signed [32:0] w_a, w_b, w_gb_ext;
    logic [GRID_BITS-1:0] w_row_addr, w_col_addr;
    logic [31:0] w_row_wd, w_col_wd;
    logic [35:0] w_md_t;
    logic [31:0] w_md, w_wt, w_x, w_max;
    logic signed [36:0] w_wq;
    logic signed [66:0] w_iv, w_ir;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ga     <= 20'sh10000;
            r_gb     <= 20'sh10000;
            r_strike <= '0;
            r_put    <= 1'b0;
            r_w0     <= 32'sh1000_0000;
            r_w1     <= 32'sh1000_0000;
            r_w2     <= 32'sh1000_0000;
            r_w3     <= 32'sh1000_0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GEARING_A: r_ga     <= i_cfg_data[19:0];
                REG_GEARING_B: r_gb     <= i_cfg_data[19:0];
                REG_STRIKE:    r_strike <= i_cfg_data;
                REG_PUT_MODE:  r_put    <= i_cfg_data[0];
                REG_PROB_UU:   r_w0     <= i_cfg_data;
                REG_PROB_UD:   r_w1     <= i_cfg_data;
                REG_PROB_DU:   r_w2     <= i_cfg_data;
                REG_PROB_DD:   r_w3     <= i_cfg_data;
            endcase
        end
    end

    // Row and column price stores, seeded from the request
    assign w_row_addr = i_ctl.ld_job ? '0 : i_ctl.row_addr;
    assign w_col_addr = i_ctl.ld_job ? '0 : i_ctl.col_addr;
    assign w_row_wd   = i_ctl.ld_job ? i_job.top_price_one : r_res;
    assign w_col_wd   = i_ctl.ld_job ? i_job.top_price_two : r_res;

    always_ff @(posedge i_clk) begin
        if (i_ctl.row_we || i_ctl.ld_job) begin
            r_row_mem[w_row_addr] <= w_row_wd;
        end
        if (i_ctl.col_we || i_ctl.ld_job) begin
            r_col_mem[w_col_addr] <= w_col_wd;
        end
        r_row_q <= r_row_mem[i_ctl.row_addr];
        r_col_q <= r_col_mem[i_ctl.col_addr];
    end

    // Node value store
    always_ff @(posedge i_clk) begin
        if (i_ctl.node_we) begin
            r_node_mem[i_ctl.node_waddr] <= r_res;
        end
        r_node_q <= r_node_mem[i_ctl.node_raddr];
    end

    // Multiplier operand selection
    assign w_gb_ext = {{13{r_gb[19]}}, r_gb};

    always_comb begin
        case (i_ctl.a_sel)
            A_P1:    w_a = {1'b0, r_p1};
            A_P2:    w_a = {1'b0, r_p2};
            A_RES:   w_a = {1'b0, r_res};
            A_ROWQ:  w_a = {1'b0, r_row_q};
            A_COLQ:  w_a = {1'b0, r_col_q};
            A_NODEQ: w_a = {1'b0, r_node_q};
            default: w_a = '0;
        endcase
        case (i_ctl.b_sel)
            B_D1:    w_b = {1'b0, r_d1};
            B_D2:    w_b = {1'b0, r_d2};
            B_GA:    w_b = {{13{r_ga[19]}}, r_ga};
            B_NGB:   w_b = -w_gb_ext;
            B_W0:    w_b = {r_w0[31], r_w0};
            B_W1:    w_b = {r_w1[31], r_w1};
            B_W2:    w_b = {r_w2[31], r_w2};
            B_W3:    w_b = {r_w3[31], r_w3};
            default: w_b = '0;
        endcase
    end

    // Registered product, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.preset)
            PRE_MD:     r_acc <= 67'sd1 <<< 30;
            PRE_WT:     r_acc <= 67'sd1 <<< 29;
            PRE_STRIKE: r_acc <= -$signed({19'b0, r_strike, 16'b0});
            default: begin
                if (r_pv) begin
                    r_acc <= r_acc + {r_prod[65], r_prod};
                end
            end
        endcase
    end

    // Price times down factor: drop 31 bits, saturate
    assign w_md_t = r_acc[66:31];
    assign w_md   = (|w_md_t[35:32]) ? 32'hFFFF_FFFF : w_md_t[31:0];

    // Weighted sum: floor by 2^30, clamp to the unsigned range
    assign w_wq = r_acc[66:30];
    always_comb begin
        if (w_wq[36] || (w_wq == '0)) begin
            w_wt = '0;
        end else if (|w_wq[35:32]) begin
            w_wt = 32'hFFFF_FFFF;
        end else begin
            w_wt = w_wq[31:0];
        end
    end

    // Intrinsic payoff: sign by mode, round at bit 16, clamp
    assign w_iv = r_put ? -r_acc : r_acc;
    assign w_ir = w_iv + 67'sh8000;
    always_comb begin
        if (w_iv[66] || (w_iv == '0)) begin
            w_x = '0;
        end else if (|w_ir[66:48]) begin
            w_x = 32'hFFFF_FFFF;
        end else begin
            w_x = w_ir[47:16];
        end
    end

    // Early exercise against continuation
    assign w_max = (w_x > r_c) ? w_x : r_c;

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_job) begin
            r_d1 <= i_job.down_one;
            r_d2 <= i_job.down_two;
            r_p1 <= i_job.top_price_one;
            r_p2 <= i_job.top_price_two;
        end else begin
            if (i_ctl.p1_ld_q) begin
                r_p1 <= r_row_q;
            end else if (i_ctl.p1_ld_res) begin
                r_p1 <= r_res;
            end
            if (i_ctl.p2_ld_q) begin
                r_p2 <= r_col_q;
            end else if (i_ctl.p2_ld_res) begin
                r_p2 <= r_res;
            end
        end
        case (i_ctl.fin)
            FIN_MD:   r_res <= w_md;
            FIN_INTR: r_res <= w_max;
            default:  ;
        endcase
        if (i_ctl.clr_c) begin
            r_c <= '0;
        end else if (i_ctl.fin == FIN_WT) begin
            r_c <= w_wt;
        end
    end

    // Result capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_ld) begin
            case (i_ctl.out_sel)
                2'd0:    r_out.value_center  <= r_node_q;
                2'd1:    r_out.value_up_up   <= r_node_q;
                2'd2:    r_out.value_up_down <= r_node_q;
                default: r_out.value_down_up <= r_node_q;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.emit;
        end
    end

    assign o_result = r_out;
    assign o_valid  = r_valid;

endmodule

// ----- sv/asot_ctrl.sv -----
module asot_ctrl import asot_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [5:0]           i_step_count,
    output logic                 o_busy,
    output t_ctl                 o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_LEAF,
        S_COLUPD,
        S_ROWUPD,
        S_NODE,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [3:0]           r_ph, n_ph;
    logic [GRID_BITS-1:0] r_i, n_i, r_j, n_j, r_w, n_w, r_s, n_s;
    logic [GRID_BITS-1:0] w_i1, w_j1, w_steps;

    assign w_i1    = r_i + GRID_BITS'(1);
    assign w_j1    = r_j + GRID_BITS'(1);
    assign w_steps = (i_step_count > MAX_STEPS) ? MAX_STEPS : i_step_count;

    // Sequencer: next state and commands
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph + 4'd1;
        n_i     = r_i;
        n_j     = r_j;
        n_w     = r_w;
        n_s     = r_s;
        o_ctl            = '0;
        o_ctl.preset     = PRE_NONE;
        o_ctl.a_sel      = A_P1;
        o_ctl.b_sel      = B_D1;
        o_ctl.fin        = FIN_NONE;
        o_ctl.row_addr   = r_i;
        o_ctl.col_addr   = r_j;
        o_ctl.node_raddr = node_addr(r_i, r_j);
        o_ctl.node_waddr = node_addr(r_i, r_j);

        unique case (r_state)
            S_IDLE: begin
                n_ph = '0;
                if (i_start) begin
                    o_ctl.ld_job = 1'b1;
                    n_state = S_FILL;
                    n_i     = GRID_BITS'(1);
                    n_s     = w_steps + GRID_BITS'(2);
                end
            end

            // Price chains: two down steps per leaf row and column
            S_FILL: begin
                o_ctl.col_addr = r_i;
                case (r_ph)
                    4'd0: begin
                        o_ctl.preset = PRE_MD; o_ctl.mul_en = 1'b1;
                        o_ctl.a_sel = A_P1; o_ctl.b_sel = B_D1;
                    end
                    4'd2, 4'd5, 4'd9, 4'd12: o_ctl.fin = FIN_MD;
                    4'd3: begin
                        o_ctl.preset = PRE_MD; o_ctl.mul_en = 1'b1;
                        o_ctl.a_sel = A_RES; o_ctl.b_sel = B_D1;
                    end
                    4'd6: begin
                        o_ctl.row_we = 1'b1; o_ctl.p1_ld_res = 1'b1;
                    end
                    4'd7: begin
                        o_ctl.preset = PRE_MD; o_ctl.mul_en = 1'b1;
                        o_ctl.a_sel = A_P2; o_ctl.b_sel = B_D2;
                    end
                    4'd10: begin
                        o_ctl.preset = PRE_MD; o_ctl.mul_en = 1'b1;
                        o_ctl.a_sel = A_RES; o_ctl.b_sel = B_D2;
                    end
                    4'd13: begin
                        o_ctl.col_we = 1'b1; o_ctl.p2_ld_res = 1'b1;
                        n_ph = '0;
                        if (r_i == r_s) begin
                            n_state = S_LEAF;
                            n_i = '0;
                            n_j = '0;
                        end else begin
                            n_i = w_i1;
                        end
                    end
                    default: ;
                endcase
            end

            // Leaf payoffs
            S_LEAF: begin
                case (r_ph)
                    4'd1: begin
                        o_ctl.p1_ld_q = 1'b1; o_ctl.p2_ld_q = 1'b1;
                        o_ctl.clr_c = 1'b1; o_ctl.preset = PRE_STRIKE;
                    end
                    4'd2: begin
                        o_ctl.mul_en = 1'b1; o_ctl.a_sel = A_P1; o_ctl.b_sel = B_GA;
                    end
                    4'd3: begin
                        o_ctl.mul_en = 1'b1; o_ctl.a_sel = A_P2; o_ctl.b_sel = B_NGB;
                    end
                    4'd5: o_ctl.fin = FIN_INTR;
                    4'd6: begin
                        o_ctl.node_we = 1'b1;
                        n_ph = '0;
                        if (r_j == r_s) begin
                            n_j = '0;
                            if (r_i == r_s) begin
                                n_i = '0;
                                n_w = r_s - GRID_BITS'(1);
                                n_state = (r_s == GRID_BITS'(2)) ? S_DONE : S_COLUPD;
                            end else begin
                                n_i = w_i1;
                            end
                        end else begin
                            n_j = w_j1;
                        end
                    end
                    default: ;
                endcase
            end

            // Column prices one step down
            S_COLUPD: begin
                case (r_ph)
                    4'd1: begin
                        o_ctl.preset = PRE_MD; o_ctl.mul_en = 1'b1;
                        o_ctl.a_sel = A_COLQ; o_ctl.b_sel = B_D2;
                    end
                    4'd3: o_ctl.fin = FIN_MD;
                    4'd4: begin
                        o_ctl.col_we = 1'b1;
                        n_ph = '0;
                        if (r_j == r_w) begin
                            n_state = S_ROWUPD;
                            n_i = '0;
                            n_j = '0;
                        end else begin
                            n_j = w_j1;
                        end
                    end
                    default: ;
                endcase
            end

            // Row price one step down
            S_ROWUPD: begin
                case (r_ph)
                    4'd1: begin
                        o_ctl.preset = PRE_MD; o_ctl.mul_en = 1'b1;
                        o_ctl.a_sel = A_ROWQ; o_ctl.b_sel = B_D1;
                    end
                    4'd3: o_ctl.fin = FIN_MD;
                    4'd4: begin
                        o_ctl.row_we = 1'b1; o_ctl.p1_ld_res = 1'b1;
                        n_ph = '0;
                        n_j = '0;
                        n_state = S_NODE;
                    end
                    default: ;
                endcase
            end

            // Node rollback: four children, then early exercise
            S_NODE: begin
                o_ctl.mul_en = 1'b0;
                case (r_ph)
                    4'd1: begin
                        o_ctl.node_raddr = node_addr(r_i, w_j1);
                        o_ctl.p2_ld_q = 1'b1; o_ctl.preset = PRE_WT;
                        o_ctl.mul_en = 1'b1; o_ctl.a_sel = A_NODEQ; o_ctl.b_sel = B_W0;
                    end
                    4'd2: begin
                        o_ctl.node_raddr = node_addr(w_i1, r_j);
                        o_ctl.mul_en = 1'b1; o_ctl.a_sel = A_NODEQ; o_ctl.b_sel = B_W1;
                    end
                    4'd3: begin
                        o_ctl.node_raddr = node_addr(w_i1, w_j1);
                        o_ctl.mul_en = 1'b1; o_ctl.a_sel = A_NODEQ; o_ctl.b_sel = B_W2;
                    end
                    4'd4: begin
                        o_ctl.mul_en = 1'b1; o_ctl.a_sel = A_NODEQ; o_ctl.b_sel = B_W3;
                    end
                    4'd6: begin
                        o_ctl.fin = FIN_WT; o_ctl.preset = PRE_STRIKE;
                        o_ctl.mul_en = 1'b1; o_ctl.a_sel = A_P1; o_ctl.b_sel = B_GA;
                    end
                    4'd7: begin
                        o_ctl.mul_en = 1'b1; o_ctl.a_sel = A_P2; o_ctl.b_sel = B_NGB;
                    end
                    4'd9: o_ctl.fin = FIN_INTR;
                    4'd10: begin
                        o_ctl.node_we = 1'b1;
                        n_ph = '0;
                        if (r_j == r_w) begin
                            n_j = '0;
                            if (r_i == r_w) begin
                                if (r_w == GRID_BITS'(2)) begin
                                    n_state = S_DONE;
                                end else begin
                                    n_w = r_w - GRID_BITS'(1);
                                    n_state = S_COLUPD;
                                end
                            end else begin
                                n_i = w_i1;
                                n_state = S_ROWUPD;
                            end
                        end else begin
                            n_j = w_j1;
                        end
                    end
                    default: ;
                endcase
            end

            // Read out the four result nodes
            S_DONE: begin
                case (r_ph)
                    4'd0: o_ctl.node_raddr = node_addr(GRID_BITS'(1), GRID_BITS'(1));
                    4'd1: begin
                        o_ctl.node_raddr = node_addr('0, '0);
                        o_ctl.out_ld = 1'b1; o_ctl.out_sel = 2'd0;
                    end
                    4'd2: begin
                        o_ctl.node_raddr = node_addr('0, GRID_BITS'(1));
                        o_ctl.out_ld = 1'b1; o_ctl.out_sel = 2'd1;
                    end
                    4'd3: begin
                        o_ctl.node_raddr = node_addr(GRID_BITS'(1), '0);
                        o_ctl.out_ld = 1'b1; o_ctl.out_sel = 2'd2;
                    end
                    4'd4: begin
                        o_ctl.out_ld = 1'b1; o_ctl.out_sel = 2'd3;
                    end
                    4'd5: begin
                        o_ctl.emit = 1'b1;
                        n_ph = '0;
                        n_state = S_IDLE;
                    end
                    default: ;
                endcase
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_w     <= '0;
            r_s     <= '0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_i     <= n_i;
            r_j     <= n_j;
            r_w     <= n_w;
            r_s     <= n_s;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- sv/american_spread_option_tree_top.sv -----
// Two-asset binomial tree pricer for an American spread option.
// Request channel: a job is taken at a clock edge with start high and busy
// low. busy stays high until the job's result has been produced.
// Result channel: o_valid is high for one cycle with o_result (premium and
// the three neighbor nodes for delta). The receiver cannot stall it; the
// result stays on o_result until the next job's readout overwrites it.
// Config channel: i_cfg_valid/o_cfg_ready with a register index and data;
// ready is always high. Write only while busy is low.
// Schedule, with s = min(N,61)+2 and one shared 33x33 multiply-accumulate:
//   the price chains, then the (s+1)^2 leaves, then for each level
//   w = s-1 down to 2: w+1 column updates, and per row one row update
//   followed by that row's w+1 nodes, then the readout. One job at a time.
// Node, row and column stores are simple dual-port RAMs that every job fills
// before reading, so reset only idles the sequencer, clears the valid flags
// and sets the config registers to their defaults; no clearing pass is needed.
module american_spread_option_tree_top import asot_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_job        i_job,
    output logic        o_valid,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_ctl w_ctl;

    assign o_cfg_ready = 1'b1;

    asot_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_step_count (i_job.step_count),
        .o_busy       (busy),
        .o_ctl        (w_ctl)
    );

    asot_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_job       (i_job),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result),
        .o_valid     (o_valid)
    );

    // Result strobe is a single cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    // An accepted request makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request accepted but not busy");

    // A result appears only after the job has left the busy phase
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy))) else $error("result while busy");

endmodule

// ----- test/american_spread_option_tree_top_test.sv -----
`timescale 1ns / 1ps

module american_spread_option_tree_top_test;
    import asot_pkg::*;

    localparam int IDLE_LIMIT = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_job        i_job;
    logic        o_valid;
    t_result     o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    american_spread_option_tree_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_job       (i_job),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Pricing state mirror
    logic signed [19:0] gear_a_m, gear_b_m;
    logic [31:0]        strike_m;
    logic               put_m;
    logic signed [31:0] weight_m [4];
    logic [31:0]        node_m [NODE_DEPTH];
    logic [31:0]        row_m [GRID_SIZE];
    logic [31:0]        col_m [GRID_SIZE];

    t_job    job_q [$];
    t_result premium_q [$];
    int      errors;
    int      idle_cycles;
    int      gap;
    logic    job_taken;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [31:0] sat_q16(longint r);
        if (r <= 0) return 32'd0;
        if (r > 64'sh0FFFFFFFF) return 32'hFFFF_FFFF;
        return r[31:0];
    endfunction

    function automatic logic [31:0] scale_down(logic [31:0] p, logic [31:0] d);
        logic [64:0] t;
        t = ({33'd0, p} * {33'd0, d} + (65'd1 << 30)) >> 31;
        return (t > 65'h0FFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    function automatic logic [31:0] payoff(logic [31:0] p1, logic [31:0] p2);
        longint v;
        v = longint'(gear_a_m) * longint'(p1) - longint'(gear_b_m) * longint'(p2)
            - (longint'(strike_m) <<< 16);
        if (put_m) v = -v;
        if (v <= 0) return 32'd0;
        return sat_q16((v + 32768) >>> 16);
    endfunction

    // Discounted four-way continuation value
    function automatic logic [31:0] hold_value(logic [31:0] a, logic [31:0] b,
                                               logic [31:0] c, logic [31:0] d);
        logic [31:0] v [4];
        longint hi, lo;
        v[0] = a; v[1] = b; v[2] = c; v[3] = d;
        hi = 0;
        lo = 0;
        for (int k = 0; k < 4; k++) begin
            hi += longint'(weight_m[k]) * longint'(v[k][31:16]);
            lo += longint'(weight_m[k]) * longint'(v[k][15:0]);
        end
        lo += longint'(1) <<< 29;
        return sat_q16((hi + (lo >>> 16)) >>> 14);
    endfunction

    function automatic t_result price_job(t_job j);
        int n, s;
        logic [31:0] c, x;
        t_result r;
        n = j.step_count;
        if (n > GRID_SIZE - 3) n = GRID_SIZE - 3;
        s = n + 2;
        row_m[0] = j.top_price_one;
        col_m[0] = j.top_price_two;
        for (int i = 1; i <= s; i++) begin
            row_m[i] = scale_down(scale_down(row_m[i-1], j.down_one), j.down_one);
            col_m[i] = scale_down(scale_down(col_m[i-1], j.down_two), j.down_two);
        end
        for (int i = 0; i <= s; i++)
            for (int k = 0; k <= s; k++)
                node_m[i*GRID_SIZE+k] = payoff(row_m[i], col_m[k]);
        // Rollback with early exercise
        for (int w = s - 1; w >= 2; w--) begin
            for (int k = 0; k <= w; k++) col_m[k] = scale_down(col_m[k], j.down_two);
            for (int i = 0; i <= w; i++) begin
                row_m[i] = scale_down(row_m[i], j.down_one);
                for (int k = 0; k <= w; k++) begin
                    c = hold_value(node_m[i*GRID_SIZE+k], node_m[i*GRID_SIZE+k+1],
                                   node_m[(i+1)*GRID_SIZE+k],
                                   node_m[(i+1)*GRID_SIZE+k+1]);
                    x = payoff(row_m[i], col_m[k]);
                    node_m[i*GRID_SIZE+k] = (x > c) ? x : c;
                end
            end
        end
        r.value_center  = node_m[GRID_SIZE+1];
        r.value_up_up   = node_m[0];
        r.value_up_down = node_m[1];
        r.value_down_up = node_m[GRID_SIZE];
        return r;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", field, got, want);
        errors++;
    endtask

    // Monitor: job acceptance, config writes, results, watchdog
    always @(posedge i_clk) begin
        t_result want;
        logic    active;
        active = 1'b0;
        job_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                active = 1'b1;
                case (i_cfg_index)
                    REG_GEARING_A: gear_a_m <= i_cfg_data[19:0];
                    REG_GEARING_B: gear_b_m <= i_cfg_data[19:0];
                    REG_STRIKE:    strike_m <= i_cfg_data;
                    REG_PUT_MODE:  put_m <= i_cfg_data[0];
                    REG_PROB_UU:   weight_m[0] <= i_cfg_data;
                    REG_PROB_UD:   weight_m[1] <= i_cfg_data;
                    REG_PROB_DU:   weight_m[2] <= i_cfg_data;
                    REG_PROB_DD:   weight_m[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                active = 1'b1;
                premium_q.push_back(price_job(i_job));
            end
            if (o_valid) begin
                active = 1'b1;
                if (premium_q.size() == 0) begin
                    report("unexpected result", o_result.value_center, 32'd0);
                end else begin
                    want = premium_q.pop_front();
                    if (o_result.value_center !== want.value_center)
                        report("value_center", o_result.value_center, want.value_center);
                    if (o_result.value_up_up !== want.value_up_up)
                        report("value_up_up", o_result.value_up_up, want.value_up_up);
                    if (o_result.value_up_down !== want.value_up_down)
                        report("value_up_down", o_result.value_up_down, want.value_up_down);
                    if (o_result.value_down_up !== want.value_down_up)
                        report("value_down_up", o_result.value_down_up, want.value_down_up);
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
            idle_cycles <= active ? 0 : idle_cycles + 1;
        end
    end

    // Driver: one request at a time with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start) begin
                if (job_taken) begin
                    void'(job_q.pop_front());
                    start <= 1'b0;
                    gap <= $urandom_range(0, 7);
                end
            end else if (gap > 0) begin
                gap <= gap - 1;
            end else if (job_q.size() > 0) begin
                start <= 1'b1;
                i_job <= job_q[0];
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic cfg_all(logic [31:0] ga, logic [31:0] gb, logic [31:0] k, logic pm,
                           logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                           logic [31:0] w3);
        cfg_write(REG_GEARING_A, ga);
        cfg_write(REG_GEARING_B, gb);
        cfg_write(REG_STRIKE, k);
        cfg_write(REG_PUT_MODE, {31'd0, pm});
        cfg_write(REG_PROB_UU, w0);
        cfg_write(REG_PROB_UD, w1);
        cfg_write(REG_PROB_DU, w2);
        cfg_write(REG_PROB_DD, w3);
    endtask

    task automatic drain();
        wait (job_q.size() == 0 && premium_q.size() == 0 && !start);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic t_job make_job(logic [31:0] p1, logic [31:0] p2,
                                      logic [31:0] d1, logic [31:0] d2, logic [5:0] n);
        t_job j;
        j.top_price_one = p1;
        j.top_price_two = p2;
        j.down_one = d1;
        j.down_two = d2;
        j.step_count = n;
        return j;
    endfunction

    function automatic logic [31:0] rand_down();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'h8000_0000;
            default: return $urandom_range(32'h6000_0000, 32'h8000_0000);
        endcase
    endfunction

    function automatic t_job rand_job();
        logic [5:0] n;
        n = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(7, 14))
                                        : 6'($urandom_range(0, 6));
        return make_job($urandom(), $urandom(), rand_down(), rand_down(), n);
    endfunction

    task automatic rand_phase(int count);
        for (int i = 0; i < count; i++) job_q.push_back(rand_job());
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_job = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        idle_cycles = 0;
        gap = 0;
        job_taken = 1'b0;
        gear_a_m = 20'sd65536;
        gear_b_m = 20'sd65536;
        strike_m = '0;
        put_m = 1'b0;
        for (int k = 0; k < 4; k++) weight_m[k] = 32'sd268435456;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: defaults, zero steps, extremes, saturated step count
        job_q.push_back(make_job(32'h0064_0000, 32'h0032_0000, 32'h7000_0000,
                                 32'h7800_0000, 6'd0));
        job_q.push_back(make_job(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 6'd1));
        job_q.push_back(make_job(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 6'd2));
        job_q.push_back(make_job(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 6'd4));
        job_q.push_back(make_job(32'h0080_0000, 32'h0040_0000, 32'h7F00_0000,
                                 32'h7E00_0000, 6'd63));
        drain();

        // Put on a strike, unequal weights
        cfg_all(32'h0001_8000, 32'h0000_8000, 32'h0050_0000, 1'b1,
                32'h1000_0000, 32'h0E00_0000, 32'h0F00_0000, 32'h1100_0000);
        job_q.push_back(make_job(32'h0010_0000, 32'h0020_0000, 32'h7000_0000,
                                 32'h7000_0000, 6'd3));
        rand_phase(20);

        // Extreme gearings and strike, large and negative weights
        cfg_all(32'h0007_FFFF, 32'h0008_0000, 32'hFFFF_FFFF, 1'b0,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000, 32'hC000_0000);
        rand_phase(20);

        cfg_all(32'h0008_0000, 32'h0007_FFFF, 32'h0, 1'b1,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        rand_phase(15);

        // Random settings
        for (int p = 0; p < 3; p++) begin
            cfg_all($urandom(), $urandom(), $urandom_range(0, 32'h00FF_FFFF),
                    1'($urandom()), $urandom_range(32'h0C00_0000, 32'h1200_0000),
                    $urandom_range(32'h0C00_0000, 32'h1200_0000), $urandom(),
                    $urandom_range(32'h0C00_0000, 32'h1200_0000));
            rand_phase(15);
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
